// ===== rtl/core/bgc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barrier gate controller package
// Shared codes, state types and timer helpers for the barrier gate controller.
// ----------------------------------------------------------------------------
package bgc_pkg;

	// Operation codes of an input item
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_UP   = 2'd1;
	localparam logic [1:0] OP_DOWN = 2'd2;
	localparam logic [1:0] OP_STOP = 2'd3;

	// Barrier state codes
	localparam logic [2:0] ST_UNKNOWN     = 3'd0;
	localparam logic [2:0] ST_DOWN        = 3'd1;
	localparam logic [2:0] ST_MOVING_UP   = 3'd2;
	localparam logic [2:0] ST_UP          = 3'd3;
	localparam logic [2:0] ST_MOVING_DOWN = 3'd4;

	// Direction of the car in transit
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_IN   = 2'd1;
	localparam logic [1:0] DIR_OUT  = 2'd2;

	// Pass stage of the car in transit
	localparam logic [1:0] STAGE_NONE   = 2'd0;
	localparam logic [1:0] STAGE_OPENED = 2'd1;
	localparam logic [1:0] STAGE_BOTH   = 2'd2;

	// Motor drive codes
	localparam logic [1:0] MD_STOP  = 2'd0;
	localparam logic [1:0] MD_RAISE = 2'd1;
	localparam logic [1:0] MD_LOWER = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_SETTLE   = 2'd0;
	localparam logic [1:0] REG_HOLD     = 2'd1;
	localparam logic [1:0] REG_CAPACITY = 2'd2;

	localparam int          CFG_W         = 16;
	localparam int          TMR_W         = 17;
	localparam logic [16:0] TMR_MAX       = 17'h1FFFF;
	localparam logic [15:0] SETTLE_RESET  = 16'd500;
	localparam logic [15:0] HOLD_RESET    = 16'd3000;
	localparam logic [7:0]  CAP_RESET     = 8'd4;

	// Elapsed-time counter with an active flag
	typedef struct packed {
		logic             active;
		logic [TMR_W-1:0] count;
	} tmr_t;

	// Controller state carried from item to item
	typedef struct packed {
		logic [2:0] mode;
		logic [1:0] dir;
		logic [1:0] stage;
		logic [7:0] occ;
		tmr_t       settle;
		tmr_t       open;
		tmr_t       holdoff;
	} bgc_state_t;

	// Fields of one input item
	typedef struct packed {
		logic [1:0] op;
		logic       at_top;
		logic       at_bottom;
		logic       car_at_entry;
		logic       car_at_exit;
	} bgc_item_t;

	localparam tmr_t TMR_IDLE = '{active: 1'b0, count: '0};

	// A timer started at a given count
	function automatic tmr_t tmr_start(input logic [TMR_W-1:0] from);
		tmr_t t;
		t.active = 1'b1;
		t.count  = from;
		return t;
	endfunction

	// One millisecond step, saturating
	function automatic tmr_t tmr_tick(input tmr_t t);
		tmr_t r;
		r = t;
		if (t.active && (t.count < TMR_MAX)) begin
			r.count = t.count + 1'b1;
		end
		return r;
	endfunction

	// True once the elapsed count exceeds the limit
	function automatic logic tmr_over(input tmr_t t, input logic [CFG_W-1:0] limit);
		return t.active && (t.count > {1'b0, limit});
	endfunction

endpackage

// ===== rtl/core/bgc_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barrier gate controller next-state logic
// Works out the controller state after one item and the result it shows.
// ----------------------------------------------------------------------------
module bgc_step (
	input  bgc_pkg::bgc_state_t cur,
	input  bgc_pkg::bgc_item_t  item,
	input  logic [15:0]         settle_ms,
	input  logic [15:0]         hold_ms,
	input  logic [7:0]          capacity,
	output bgc_pkg::bgc_state_t nxt,
	output logic [1:0]          motor_drive
);
	import bgc_pkg::*;

	bgc_state_t s;

	// Manual commands act at once; a tick advances the timers and runs the
	// automatic sequence in the order the rules are given.
	always_comb begin
		s = cur;
		unique case (item.op)
			OP_TICK: begin
				s.settle  = tmr_tick(s.settle);
				s.open    = tmr_tick(s.open);
				s.holdoff = tmr_tick(s.holdoff);

				// Unknown position with nothing held off: lower the barrier
				if (!item.at_top && !item.at_bottom && s.mode == ST_UNKNOWN &&
				    (!s.holdoff.active || tmr_over(s.holdoff, hold_ms))) begin
					s.mode    = ST_MOVING_DOWN;
					s.settle  = tmr_start({1'b0, settle_ms});
					s.holdoff = TMR_IDLE;
				end
				// Limit switches are believed once the move has settled
				if (item.at_bottom && tmr_over(s.settle, settle_ms)) begin
					s.mode   = ST_DOWN;
					s.settle = TMR_IDLE;
				end
				if (item.at_top && tmr_over(s.settle, settle_ms)) begin
					s.mode   = ST_UP;
					s.settle = TMR_IDLE;
				end
				// Hold-open timer starts once the barrier is up
				if (s.mode == ST_UP && !s.open.active &&
				    (!s.settle.active || tmr_over(s.settle, settle_ms))) begin
					s.open = tmr_start('0);
				end

				// Car passage sequencing
				if (!s.holdoff.active) begin
					if (item.car_at_entry) begin
						if (s.mode != ST_UP) begin
							if (s.occ < capacity) begin
								s.mode  = ST_MOVING_UP;
								if (!s.settle.active) s.settle = tmr_start('0);
								s.dir   = DIR_IN;
								s.stage = STAGE_OPENED;
							end
						end else if (s.dir == DIR_OUT && s.stage == STAGE_OPENED) begin
							s.stage = STAGE_BOTH;
						end
					end else if (s.dir == DIR_OUT && s.stage == STAGE_BOTH) begin
						s.dir   = DIR_NONE;
						s.stage = STAGE_NONE;
						s.mode  = ST_MOVING_DOWN;
						if (!s.settle.active) s.settle = tmr_start('0);
						if (s.occ != 8'd0) s.occ = s.occ - 1'b1;
					end
					if (item.car_at_exit) begin
						if (s.mode != ST_UP) begin
							s.mode  = ST_MOVING_UP;
							if (!s.settle.active) s.settle = tmr_start('0);
							s.dir   = DIR_OUT;
							s.stage = STAGE_OPENED;
						end else if (s.dir == DIR_IN && s.stage == STAGE_OPENED) begin
							s.stage = STAGE_BOTH;
						end
					end else if (s.dir == DIR_IN && s.stage == STAGE_BOTH) begin
						s.dir   = DIR_NONE;
						s.stage = STAGE_NONE;
						s.mode  = ST_MOVING_DOWN;
						if (!s.settle.active) s.settle = tmr_start('0);
						if (s.occ < capacity) s.occ = s.occ + 1'b1;
					end
				end

				// Automatic close after the idle open time
				if (!item.car_at_exit && !item.car_at_entry && item.at_top &&
				    tmr_over(s.open, hold_ms)) begin
					s.open   = TMR_IDLE;
					s.mode   = ST_MOVING_DOWN;
					s.settle = tmr_start('0);
					s.stage  = STAGE_NONE;
					s.dir    = DIR_NONE;
				end
			end
			OP_UP: begin
				if (!item.at_top) begin
					s.mode = ST_MOVING_UP;
					if (!s.settle.active) s.settle = tmr_start('0);
				end
			end
			OP_DOWN: begin
				if (!item.at_bottom) begin
					s.mode = ST_MOVING_DOWN;
					if (!s.settle.active) s.settle = tmr_start('0);
				end
			end
			OP_STOP: begin
				if (item.at_bottom) begin
					s.mode    = ST_DOWN;
					s.holdoff = TMR_IDLE;
				end else begin
					s.mode    = ST_UNKNOWN;
					s.holdoff = tmr_start('0);
				end
			end
			default: begin
				s = cur;
			end
		endcase
	end

	assign nxt = s;

	// Motor follows the new barrier state
	always_comb begin
		priority if (s.mode == ST_MOVING_UP) motor_drive = MD_RAISE;
		else if (s.mode == ST_MOVING_DOWN) motor_drive = MD_LOWER;
		else motor_drive = MD_STOP;
	end

endmodule

// ===== rtl/core/barrier_gate_controller.sv =====
`timescale 1ns / 1ps
// An accepted item waits in the input register, which feeds the result register
// through the state logic. Throughput: one item per cycle while the result side
// does not stall; the state update is a single pass of logic between the two.
// Reset clears the barrier state, occupancy, timers and pipeline valids, and
// loads the settle, hold and capacity registers with 500, 3000 and 4.
// ----------------------------------------------------------------------------
// Barrier gate controller
// Parking barrier control with car pass sequencing, occupancy count and timers.
// ----------------------------------------------------------------------------
module barrier_gate_controller (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data,
	// Input item channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic        at_top,
	input  logic        at_bottom,
	input  logic        car_at_entry,
	input  logic        car_at_exit,
	// Result item channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  motor_drive,
	output logic [2:0]  barrier_state,
	output logic [7:0]  cars_parked
);
	import bgc_pkg::*;

	logic [15:0] settle_ms_q;
	logic [15:0] hold_ms_q;
	logic [7:0]  capacity_q;
	bgc_state_t  state_q;
	bgc_state_t  state_nxt;
	bgc_item_t   item_s1;
	logic        valid_s1;
	logic        out_valid_q;
	logic [1:0]  motor_drive_q;
	logic [2:0]  barrier_state_q;
	logic [7:0]  cars_parked_q;
	logic [1:0]  motor_nxt;
	logic        advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_ms_q <= SETTLE_RESET;
			hold_ms_q   <= HOLD_RESET;
			capacity_q  <= CAP_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SETTLE:   settle_ms_q <= wr_data;
				REG_HOLD:     hold_ms_q   <= wr_data;
				REG_CAPACITY: capacity_q  <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	// The item in the input register moves on when the result register is free
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{op: op, at_top: at_top, at_bottom: at_bottom,
			             car_at_entry: car_at_entry, car_at_exit: car_at_exit};
		end
	end

	// Next-state logic
	bgc_step u_step (
		.cur         (state_q),
		.item        (item_s1),
		.settle_ms   (settle_ms_q),
		.hold_ms     (hold_ms_q),
		.capacity    (capacity_q),
		.nxt         (state_nxt),
		.motor_drive (motor_nxt)
	);

	// Controller state, updated as each item passes into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: ST_UNKNOWN, dir: DIR_NONE, stage: STAGE_NONE, occ: 8'd0,
			             settle: TMR_IDLE, open: TMR_IDLE, holdoff: TMR_IDLE};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			motor_drive_q   <= motor_nxt;
			barrier_state_q <= state_nxt.mode;
			cars_parked_q   <= state_nxt.occ;
		end
	end

	assign out_valid     = out_valid_q;
	assign motor_drive   = motor_drive_q;
	assign barrier_state = barrier_state_q;
	assign cars_parked   = cars_parked_q;

	// A car in transit always has both a direction and a pass stage
	a_transit_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.stage == STAGE_NONE) == (state_q.dir == DIR_NONE))
		else $error("pass stage and transit direction disagree");

	// A stopped timer holds a zero count
	a_timers_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.settle.active || state_q.settle.count == '0) &&
		(state_q.open.active || state_q.open.count == '0) &&
		(state_q.holdoff.active || state_q.holdoff.count == '0))
		else $error("inactive timer holds a nonzero count");

	// Every item leaving the input register shows up as a result next cycle
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced item produced no result");

	// Motor drive agrees with the barrier state shown beside it
	a_motor_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((motor_drive_q == MD_RAISE) == (barrier_state_q == ST_MOVING_UP)) &&
		                ((motor_drive_q == MD_LOWER) == (barrier_state_q == ST_MOVING_DOWN)))
		else $error("motor drive disagrees with barrier state");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barrier gate controller testbench
// Drives tick and manual command items with limit-switch and car-sensor levels
// into the controller, predicts every result item with a behavioural model of
// the barrier, pass sequencing, occupancy and timers, and compares each result
// field by field. Directed passes come first, then phases of random traffic
// built from complete car passes with noise, then a run at the register maxima.
// ----------------------------------------------------------------------------
module testbench;
	import bgc_pkg::*;

	// Steps of a scripted car pass
	localparam int SCRIPT_WAIT  = 0;
	localparam int SCRIPT_BOTH  = 1;
	localparam int SCRIPT_CROSS = 2;
	localparam int SCRIPT_LEAVE = 3;

	localparam int STUCK_LIMIT = 1000;

	// Expected fields of one result item
	typedef struct packed {
		logic [1:0] motor;
		logic [2:0] state;
		logic [7:0] parked;
	} gate_out_t;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        wr_en        = 1'b0;
	logic [1:0]  wr_index     = REG_SETTLE;
	logic [15:0] wr_data      = 16'd0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [1:0]  op           = OP_TICK;
	logic        at_top       = 1'b0;
	logic        at_bottom    = 1'b0;
	logic        car_at_entry = 1'b0;
	logic        car_at_exit  = 1'b0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [1:0]  motor_drive;
	logic [2:0]  barrier_state;
	logic [7:0]  cars_parked;

	// Predicted controller state and register copies
	logic [2:0]  g_mode    = ST_UNKNOWN;
	logic [1:0]  g_dir     = DIR_NONE;
	logic [1:0]  g_stage   = STAGE_NONE;
	logic [7:0]  g_occ     = 8'd0;
	tmr_t        g_settle  = TMR_IDLE;
	tmr_t        g_open    = TMR_IDLE;
	tmr_t        g_holdoff = TMR_IDLE;
	logic [15:0] cfg_settle   = SETTLE_RESET;
	logic [15:0] cfg_hold     = HOLD_RESET;
	logic [7:0]  cfg_capacity = CAP_RESET;

	gate_out_t   results_due[$];
	bit          idle_on = 1'b1;
	int          items_sent;
	int          results_seen;
	int          settings_used;
	int          mismatches;
	int          stuck_cycles;

	// Sensor levels and car script of the random traffic
	logic        top_lv, bot_lv, entry_lv, exit_lv;
	int          car_kind;
	int          car_step;
	int          car_left;

	barrier_gate_controller dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.at_top       (at_top),
		.at_bottom    (at_bottom),
		.car_at_entry (car_at_entry),
		.car_at_exit  (car_at_exit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.motor_drive  (motor_drive),
		.barrier_state(barrier_state),
		.cars_parked  (cars_parked)
	);

	// Clock of 10 ns period.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Elapsed-time counters of the prediction.
	function automatic tmr_t span_begin(input logic [16:0] from);
		tmr_t t;
		t.active = 1'b1;
		t.count  = from;
		return t;
	endfunction

	function automatic tmr_t span_step(input tmr_t t);
		tmr_t r;
		r = t;
		if (t.active && (t.count != 17'h1FFFF)) begin
			r.count = t.count + 17'd1;
		end
		return r;
	endfunction

	function automatic logic span_past(input tmr_t t, input logic [15:0] lim);
		return t.active && (t.count > {1'b0, lim});
	endfunction

	// A move only restarts the settle count when none is running.
	function automatic void settle_from_rest();
		if (!g_settle.active) begin
			g_settle = span_begin(17'd0);
		end
	endfunction

	// A car has gone through: the barrier closes behind it.
	function automatic void pass_done();
		g_dir   = DIR_NONE;
		g_stage = STAGE_NONE;
		g_mode  = ST_MOVING_DOWN;
		settle_from_rest();
	endfunction

	// Automatic control on a tick.
	function automatic void gate_auto(input logic top, input logic bot, input logic ent,
			input logic ext);
		// Position unknown and free to move: lower, settle counted as elapsed.
		if (!top && !bot && (g_mode == ST_UNKNOWN) &&
				(!g_holdoff.active || span_past(g_holdoff, cfg_hold))) begin
			g_mode    = ST_MOVING_DOWN;
			g_settle  = span_begin({1'b0, cfg_settle});
			g_holdoff = TMR_IDLE;
		end
		if (bot && span_past(g_settle, cfg_settle)) begin
			g_mode   = ST_DOWN;
			g_settle = TMR_IDLE;
		end
		if (top && span_past(g_settle, cfg_settle)) begin
			g_mode   = ST_UP;
			g_settle = TMR_IDLE;
		end
		if ((g_mode == ST_UP) && !g_open.active &&
				(!g_settle.active || span_past(g_settle, cfg_settle))) begin
			g_open = span_begin(17'd0);
		end

		// Car pass sequencing, held off after a manual stop.
		if (!g_holdoff.active) begin
			if (ent) begin
				if (g_mode != ST_UP) begin
					if (g_occ < cfg_capacity) begin
						g_mode = ST_MOVING_UP;
						settle_from_rest();
						g_dir   = DIR_IN;
						g_stage = STAGE_OPENED;
					end
				end else if ((g_dir == DIR_OUT) && (g_stage == STAGE_OPENED)) begin
					g_stage = STAGE_BOTH;
				end
			end else if ((g_dir == DIR_OUT) && (g_stage == STAGE_BOTH)) begin
				pass_done();
				if (g_occ != 8'd0) begin
					g_occ = g_occ - 8'd1;
				end
			end
			if (ext) begin
				if (g_mode != ST_UP) begin
					g_mode = ST_MOVING_UP;
					settle_from_rest();
					g_dir   = DIR_OUT;
					g_stage = STAGE_OPENED;
				end else if ((g_dir == DIR_IN) && (g_stage == STAGE_OPENED)) begin
					g_stage = STAGE_BOTH;
				end
			end else if ((g_dir == DIR_IN) && (g_stage == STAGE_BOTH)) begin
				pass_done();
				if (g_occ < cfg_capacity) begin
					g_occ = g_occ + 8'd1;
				end
			end
		end

		// Idle open barrier closes once the hold time has passed.
		if (!ext && !ent && top && span_past(g_open, cfg_hold)) begin
			g_open   = TMR_IDLE;
			g_mode   = ST_MOVING_DOWN;
			g_settle = span_begin(17'd0);
			g_stage  = STAGE_NONE;
			g_dir    = DIR_NONE;
		end
	endfunction

	// Advances the predicted controller by one item and gives its result.
	function automatic gate_out_t advance_gate(input logic [1:0] o, input logic top,
			input logic bot, input logic ent, input logic ext);
		gate_out_t r;
		case (o)
			OP_TICK: begin
				g_settle  = span_step(g_settle);
				g_open    = span_step(g_open);
				g_holdoff = span_step(g_holdoff);
				gate_auto(top, bot, ent, ext);
			end
			OP_UP: begin
				if (!top) begin
					g_mode = ST_MOVING_UP;
					settle_from_rest();
				end
			end
			OP_DOWN: begin
				if (!bot) begin
					g_mode = ST_MOVING_DOWN;
					settle_from_rest();
				end
			end
			default: begin
				if (bot) begin
					g_mode    = ST_DOWN;
					g_holdoff = TMR_IDLE;
				end else begin
					g_mode    = ST_UNKNOWN;
					g_holdoff = span_begin(17'd0);
				end
			end
		endcase
		r.motor  = (g_mode == ST_MOVING_UP) ? MD_RAISE :
			((g_mode == ST_MOVING_DOWN) ? MD_LOWER : MD_STOP);
		r.state  = g_mode;
		r.parked = g_occ;
		return r;
	endfunction

	// Sends one item after a random gap and records its expected result.
	task automatic send_item(input logic [1:0] o, input logic t, input logic b,
			input logic e, input logic x);
		int gap;
		gap = idle_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		op           <= o;
		at_top       <= t;
		at_bottom    <= b;
		car_at_entry <= e;
		car_at_exit  <= x;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		results_due.push_back(advance_gate(o, t, b, e, x));
		items_sent++;
	endtask

	// Waits until every expected result has come and the block has gone quiet.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes one register; only called while the block is idle.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_SETTLE:   cfg_settle   = val;
			REG_HOLD:     cfg_hold     = val;
			REG_CAPACITY: cfg_capacity = val[7:0];
			default:      ;
		endcase
	endtask

	// Reset values: unknown position lowers at once, then bottom is believed.
	task automatic test_power_up();
		settings_used++;
		send_item(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
		send_item(OP_TICK, 1'b0, 1'b1, 1'b0, 1'b0);
	endtask

	// Manual commands, their ignored cases and the hold-off after a stop.
	task automatic test_manual_commands();
		send_item(OP_UP,   1'b1, 1'b0, 1'b0, 1'b0);
		send_item(OP_DOWN, 1'b0, 1'b1, 1'b0, 1'b0);
		send_item(OP_UP,   1'b0, 1'b1, 1'b0, 1'b0);
		send_item(OP_STOP, 1'b0, 1'b0, 1'b0, 1'b0);
		send_item(OP_TICK, 1'b0, 1'b0, 1'b1, 1'b1);
		send_item(OP_STOP, 1'b0, 1'b1, 1'b0, 1'b0);
		send_item(OP_DOWN, 1'b1, 1'b0, 1'b0, 1'b0);
		send_item(OP_TICK, 1'b1, 1'b1, 1'b1, 1'b1);
	endtask

	// Inbound pass, refusal at full, outbound pass, all with settle, hold and capacity at 1.
	task automatic test_car_passes();
		drain_results();
		write_reg(REG_SETTLE, 16'd1);
		write_reg(REG_HOLD, 16'd1);
		write_reg(REG_CAPACITY, 16'd1);
		settings_used++;
		send_item(OP_TICK, 1'b0, 1'b1, 1'b0, 1'b0);
		send_item(OP_TICK, 1'b0, 1'b1, 1'b0, 1'b0);
		send_item(OP_TICK, 1'b0, 1'b1, 1'b1, 1'b0);
		send_item(OP_TICK, 1'b1, 1'b0, 1'b1, 1'b0);
		send_item(OP_TICK, 1'b1, 1'b0, 1'b1, 1'b0);
		send_item(OP_TICK, 1'b1, 1'b0, 1'b1, 1'b1);
		send_item(OP_TICK, 1'b1, 1'b0, 1'b0, 1'b1);
		send_item(OP_TICK, 1'b1, 1'b0, 1'b0, 1'b0);
		send_item(OP_TICK, 1'b0, 1'b1, 1'b0, 1'b0);
		send_item(OP_TICK, 1'b0, 1'b1, 1'b0, 1'b0);
		send_item(OP_TICK, 1'b0, 1'b1, 1'b1, 1'b0);
		send_item(OP_TICK, 1'b0, 1'b1, 1'b0, 1'b1);
		send_item(OP_TICK, 1'b1, 1'b0, 1'b0, 1'b1);
		send_item(OP_TICK, 1'b1, 1'b0, 1'b0, 1'b1);
		send_item(OP_TICK, 1'b1, 1'b0, 1'b1, 1'b1);
		send_item(OP_TICK, 1'b1, 1'b0, 1'b1, 1'b0);
		send_item(OP_TICK, 1'b1, 1'b0, 1'b0, 1'b0);
	endtask

	// Random traffic: mostly scripted car passes with switches that follow the
	// barrier, the rest manual commands and random sensor levels.
	task automatic drive_traffic(input int n);
		int         k;
		int         r;
		logic [31:0] rnd;
		logic [1:0] o;
		logic       t, b, e, x;
		for (k = 0; k < n; k++) begin
			r   = $urandom_range(0, 99);
			rnd = $urandom;
			if (r < 5) begin
				o = rnd[1:0];
				if (o == OP_TICK) begin
					o = OP_STOP;
				end
				{t, b, e, x} = rnd[7:4];
			end else if (r < 10) begin
				o = OP_TICK;
				{t, b, e, x} = rnd[7:4];
			end else begin
				o = OP_TICK;
				// Limit switches follow the predicted barrier, with rare glitches.
				case (g_mode)
					ST_MOVING_UP: begin
						bot_lv = 1'b0;
						if (rnd[9:8] == 2'd0) top_lv = 1'b1;
					end
					ST_MOVING_DOWN: begin
						top_lv = 1'b0;
						if (rnd[9:8] == 2'd0) bot_lv = 1'b1;
					end
					ST_UP: begin
						top_lv = 1'b1;
						bot_lv = 1'b0;
					end
					ST_DOWN: begin
						top_lv = 1'b0;
						bot_lv = 1'b1;
					end
					default: begin
						if (rnd[12:10] == 3'd0) {top_lv, bot_lv} = rnd[14:13];
					end
				endcase
				if (rnd[19:15] == 5'd0) top_lv = ~top_lv;

				// Start a new car now and then.
				if (car_kind == 0) begin
					if ($urandom_range(0, 5) == 0) begin
						car_kind = rnd[20] ? DIR_OUT : DIR_IN;
						car_step = SCRIPT_WAIT;
						car_left = 80;
					end
				end

				// Sensor levels for the current step of the pass.
				case (car_step)
					SCRIPT_WAIT:  {entry_lv, exit_lv} = (car_kind == DIR_IN) ? 2'b10 : 2'b01;
					SCRIPT_BOTH:  {entry_lv, exit_lv} = 2'b11;
					SCRIPT_CROSS: {entry_lv, exit_lv} = (car_kind == DIR_IN) ? 2'b01 : 2'b10;
					default:      {entry_lv, exit_lv} = 2'b00;
				endcase
				if (car_kind == 0) begin
					{entry_lv, exit_lv} = 2'b00;
				end else begin
					// The car waits for the barrier, gives up if refused.
					car_left--;
					if (car_step == SCRIPT_WAIT) begin
						if ((g_mode == ST_UP) && ($urandom_range(0, 2) == 0)) begin
							car_step = SCRIPT_BOTH;
							car_left = $urandom_range(1, 6);
						end else if (car_left <= 0) begin
							car_step = SCRIPT_LEAVE;
							car_left = $urandom_range(1, 4);
						end
					end else if (car_left <= 0) begin
						if (car_step == SCRIPT_LEAVE) begin
							car_kind = 0;
						end else begin
							car_step = car_step + 1;
							car_left = $urandom_range(1, 6);
						end
					end
				end
				t = top_lv;
				b = bot_lv;
				e = entry_lv;
				x = exit_lv;
			end
			send_item(o, t, b, e, x);
		end
	endtask

	// Phases of random traffic, each under fresh register settings.
	task automatic test_random_traffic();
		int          ph;
		logic [31:0] rnd;
		top_lv   = 1'b0;
		bot_lv   = 1'b1;
		entry_lv = 1'b0;
		exit_lv  = 1'b0;
		car_kind = 0;
		car_step = SCRIPT_WAIT;
		car_left = 0;
		for (ph = 0; ph < 12; ph++) begin
			drain_results();
			rnd = (ph == 9) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			write_reg(REG_SETTLE, rnd[15:0]);
			rnd = $urandom_range(1, 24);
			write_reg(REG_HOLD, rnd[15:0]);
			// Full-size lot once, and a lot of one place so the count can sit above it.
			rnd = (ph == 4) ? 32'd255 : ((ph == 7) ? 32'd1 : $urandom_range(1, 5));
			write_reg(REG_CAPACITY, rnd[15:0]);
			settings_used++;
			idle_on = ($urandom_range(0, 3) != 0);
			drive_traffic(150);
		end
	endtask

	// Register maxima: a short stretch of back-to-back ticks at the longest
	// settle and hold times, during which no limit switch is believed yet.
	task automatic test_timer_extremes();
		int k;
		drain_results();
		write_reg(REG_SETTLE, 16'hFFFF);
		write_reg(REG_HOLD, 16'hFFFF);
		write_reg(REG_CAPACITY, 16'd255);
		settings_used++;
		idle_on = 1'b0;
		send_item(OP_UP, 1'b0, 1'b0, 1'b0, 1'b0);
		for (k = 0; k < 24; k++) begin
			send_item(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
		end
		for (k = 0; k < 24; k++) begin
			send_item(OP_TICK, 1'b1, 1'b0, 1'b0, 1'b0);
		end
		idle_on = 1'b1;
		send_item(OP_TICK, 1'b0, 1'b1, 1'b0, 1'b0);
		send_item(OP_STOP, 1'b0, 1'b1, 1'b0, 1'b0);
	endtask

	// Receiver back-pressure: a random stall before each result item.
	initial begin : result_backpressure
		int stall_len;
		forever begin
			stall_len = idle_on ? $urandom_range(0, 16) : 0;
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Result checking against the oldest expectation.
	always @(posedge clk) begin : check_results
		gate_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (results_due.size() == 0) begin
				$error("result item with no expectation: motor_drive %0d barrier_state %0d cars_parked %0d",
					motor_drive, barrier_state, cars_parked);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				if (motor_drive !== want.motor) begin
					$error("motor_drive: expected %0d, got %0d", want.motor, motor_drive);
					mismatches++;
				end
				if (barrier_state !== want.state) begin
					$error("barrier_state: expected %0d, got %0d", want.state, barrier_state);
					mismatches++;
				end
				if (cars_parked !== want.parked) begin
					$error("cars_parked: expected %0d, got %0d", want.parked, cars_parked);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles in which nothing moves.
	always @(posedge clk) begin
		if (!arst_n || wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles, %0d results outstanding",
				STUCK_LIMIT, results_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_up();
		test_manual_commands();
		test_car_passes();
		test_random_traffic();
		test_timer_extremes();
		drain_results();
		repeat (8) @(negedge clk);
		if (results_due.size() != 0) begin
			$error("%0d expected result items never arrived", results_due.size());
			mismatches++;
		end
		$display("Sent %0d items (ticks, manual commands, car passes) and checked %0d results",
			items_sent, results_seen);
		$display("under %0d register settings, from the lowest values up to the maxima",
			settings_used);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
